// ===== sv/htfd_pkg.sv =====
// Shared types, constants and the CRC8 byte update for the sensor frame decoder.
// No dependencies; design files use scoped names, verif files import it.
package htfd_pkg;

  // Frame layout and CRC
  localparam logic [2:0] LAST_POS  = 3'd6;
  localparam logic [7:0] CRC_INIT  = 8'hFF;
  localparam logic [7:0] CRC_POLY  = 8'h31;
  localparam int unsigned BUSY_BIT = 7;
  localparam logic [7:0] CAL_MASK  = 8'h18;

  // Conversion scale factors and temperature offset (0.01 unit steps)
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [14:0] TEMP_SCALE  = 15'd20000;
  localparam logic [15:0] TEMP_OFFSET = 16'd5000;

  // Result status codes
  typedef enum logic [1:0] {
    FRAME_OK      = 2'd0,
    FRAME_BUSY    = 2'd1,
    FRAME_CRC_ERR = 2'd2
  } frame_status_t;

  // Decoded frame handed from the front end to the conversion back end
  typedef struct packed {
    frame_status_t frame_status;
    logic          needs_calibration;
    logic [19:0]   humidity_raw;
    logic [19:0]   temperature_raw;
  } frame_rec_t;

  // Finished result held in the output register
  typedef struct packed {
    frame_status_t frame_status;
    logic          needs_calibration;
    logic [19:0]   humidity_raw;
    logic [19:0]   temperature_raw;
    logic [13:0]   humidity_centi;
    logic [14:0]   temperature_centi;
  } result_t;

  // CRC8, MSB first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/htfd_front.sv =====
// Front end: tracks the byte position, runs the CRC and assembles the payload.
// Pushes one decoded frame record per CRC byte. Depends on htfd_pkg.
module htfd_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            data_byte,
  input  logic                  frame_start,
  input  logic                  queue_full,
  output logic                  push,
  output htfd_pkg::frame_rec_t  rec
);

  logic [2:0]  byte_position;
  logic [7:0]  running_crc;
  logic [7:0]  status_hold;
  logic [39:0] payload_shift;

  logic        accept;
  logic [2:0]  pos_eff;
  logic [7:0]  crc_step;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign crc_step = htfd_pkg::crc8_byte((pos_eff == 3'd0) ? htfd_pkg::CRC_INIT : running_crc,
                                        data_byte);

  // Resynchronize on a start mark or an out-of-range count
  always_comb begin
    if (frame_start || byte_position > htfd_pkg::LAST_POS) begin
      pos_eff = 3'd0;
    end else begin
      pos_eff = byte_position;
    end
  end

  // Build the frame record on the CRC byte
  always_comb begin
    rec.needs_calibration = (status_hold & htfd_pkg::CAL_MASK) != htfd_pkg::CAL_MASK;
    rec.humidity_raw      = payload_shift[39:20];
    rec.temperature_raw   = payload_shift[19:0];
    priority if (status_hold[htfd_pkg::BUSY_BIT]) begin
      rec.frame_status = htfd_pkg::FRAME_BUSY;
    end else if (running_crc != data_byte) begin
      rec.frame_status = htfd_pkg::FRAME_CRC_ERR;
    end else begin
      rec.frame_status = htfd_pkg::FRAME_OK;
    end
  end

  assign push = accept && (pos_eff == htfd_pkg::LAST_POS);

  // Advance the position and the CRC
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 3'd0;
      running_crc   <= htfd_pkg::CRC_INIT;
    end else if (accept) begin
      if (pos_eff == htfd_pkg::LAST_POS) begin
        byte_position <= 3'd0;
        running_crc   <= htfd_pkg::CRC_INIT;
      end else begin
        byte_position <= pos_eff + 3'd1;
        running_crc   <= crc_step;
      end
    end
  end

  // Capture the status byte and shift in the payload
  always_ff @(posedge clk) begin
    if (accept) begin
      if (pos_eff == 3'd0) begin
        status_hold   <= data_byte;
        payload_shift <= '0;
      end else if (pos_eff != htfd_pkg::LAST_POS) begin
        payload_shift <= {payload_shift[31:0], data_byte};
      end
    end
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (rst) push |-> !queue_full)
    else $error("frame record pushed into a full queue");

endmodule

// ===== sv/htfd_queue.sv =====
// Short FIFO of decoded frame records between the front end and the back end.
// Depends on htfd_pkg for the record type.
module htfd_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  htfd_pkg::frame_rec_t  push_rec,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output htfd_pkg::frame_rec_t  head_rec
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  htfd_pkg::frame_rec_t mem [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign head_rec  = mem[rd_ptr];

  // Store the pushed record
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + IDX_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + IDX_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("queue fill count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("pop from an empty queue");

endmodule

// ===== sv/htfd_back.sv =====
// Back end: scales the raw values to 0.01 units in two stages and holds the result.
// Stage one registers the products, stage two is the output register. Depends on htfd_pkg.
module htfd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rec_valid,
  input  htfd_pkg::frame_rec_t  rec,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output htfd_pkg::result_t     result
);

  logic                  s1_valid;
  htfd_pkg::frame_rec_t  s1_rec;
  logic [33:0]           hum_prod;
  logic [34:0]           tmp_prod;

  logic                  out_take;
  logic                  s1_take;
  logic [15:0]           tmp_diff;

  assign out_take = !out_valid || out_ready;
  assign s1_take  = !s1_valid || out_take;
  assign pop      = rec_valid && s1_take;

  // Stage one: multiply by the scale factors
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_take) begin
      s1_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_rec   <= rec;
      hum_prod <= 34'(rec.humidity_raw) * 34'(htfd_pkg::HUM_SCALE);
      tmp_prod <= 35'(rec.temperature_raw) * 35'(htfd_pkg::TEMP_SCALE);
    end
  end

  // Floor by the shift, then remove the temperature offset
  assign tmp_diff = {1'b0, tmp_prod[34:20]} - htfd_pkg::TEMP_OFFSET;

  // Stage two: output register, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && out_take) begin
      result.frame_status      <= s1_rec.frame_status;
      result.needs_calibration <= s1_rec.needs_calibration;
      result.humidity_raw      <= s1_rec.humidity_raw;
      result.temperature_raw   <= s1_rec.temperature_raw;
      result.humidity_centi    <= hum_prod[33:20];
      result.temperature_centi <= tmp_diff[14:0];
    end
  end

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
                               (s1_valid && !out_take) |=> s1_valid)
    else $error("stage one item lost while output stalled");

endmodule

// ===== sv/humidity_temp_frame_decoder.sv =====
// Top level of the humidity and temperature sensor frame decoder.
// Instantiates htfd_front, htfd_queue and htfd_back; depends on htfd_pkg.
//
//   channel   direction  width  contents
//   s_axis    in         8+1    one frame byte, tuser = start of frame
//   m_axis    out        72     one decoded result per seven-byte frame
//
// One byte is accepted every cycle while the record queue has room.
// After its CRC byte is accepted, a record is written to the queue, then loaded
// into the product register, then into the output register, where the result
// is offered; a stalled output can hold it in any of these.
// Reset clears the byte position, the CRC, the queue and both valid flags.
// A stalled output fills the stage registers and then the queue (QUEUE_DEPTH
// frames) before s_axis_tready drops; the input side never waits on the output
// while room is left.
module humidity_temp_frame_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // [1:0] frame_status, [2] needs_calibration,
                                      // [22:3] humidity_raw, [42:23] temperature_raw,
                                      // [56:43] humidity_centi, [71:57] temperature_centi
);

  logic                  push;
  logic                  queue_full;
  logic                  queue_not_empty;
  logic                  pop;
  htfd_pkg::frame_rec_t  front_rec;
  htfd_pkg::frame_rec_t  head_rec;
  htfd_pkg::result_t     result;

  htfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .data_byte   (s_axis_tdata),
    .frame_start (s_axis_tuser),
    .queue_full  (queue_full),
    .push        (push),
    .rec         (front_rec)
  );

  htfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (front_rec),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (queue_not_empty),
    .head_rec  (head_rec)
  );

  htfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (queue_not_empty),
    .rec       (head_rec),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .result    (result)
  );

  // Pack the result, first field in the lowest bits
  assign m_axis_tdata = {result.temperature_centi, result.humidity_centi,
                         result.temperature_raw, result.humidity_raw,
                         result.needs_calibration, result.frame_status};

endmodule

// ===== verif/htfd_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the humidity and temperature frame decoder.
// Follows the byte stream, predicts each decoded frame and compares it with the result stream.
// Depends on htfd_pkg for the status codes, the result layout and the frame constants.
module htfd_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] frame_start
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,   // [1:0] frame_status, [2] needs_calibration,
                                      // [22:3] humidity_raw, [42:23] temperature_raw,
                                      // [56:43] humidity_centi, [71:57] temperature_centi
  output int          fail_count,
  output int          frames_pending
);
  import htfd_pkg::*;

  localparam longint unsigned HUM_FULL_SCALE  = 64'd10000;
  localparam longint unsigned TEMP_FULL_SCALE = 64'd20000;
  localparam longint unsigned TEMP_SHIFT_DOWN = 64'd5000;

  // Predicted frame state
  logic [2:0]  frame_pos;
  logic [7:0]  crc_acc;
  logic [7:0]  status_byte;
  logic [39:0] payload_bytes;
  result_t     expected_readings[$];
  int          results_seen;

  task automatic flag_error(input string msg);
    $display("[%0t] %s", $time, msg);
    fail_count++;
  endtask

  // CRC8, poly 0x31, fed one data bit at a time, MSB first
  function automatic logic [7:0] crc_shift(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ b[i];
      r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  // Advance the predicted frame by one accepted item; queue a reading on the CRC byte
  task automatic decode_byte(input logic [7:0] b, input logic start_mark);
    result_t         r;
    logic [2:0]      pos;
    longint unsigned prod;
    pos = (start_mark || frame_pos > LAST_POS) ? 3'd0 : frame_pos;
    if (pos == 3'd0) begin
      status_byte   = b;
      payload_bytes = '0;
      crc_acc       = crc_shift(CRC_INIT, b);
      frame_pos     = 3'd1;
    end else if (pos < LAST_POS) begin
      payload_bytes = {payload_bytes[31:0], b};
      crc_acc       = crc_shift(crc_acc, b);
      frame_pos     = pos + 3'd1;
    end else begin
      r.humidity_raw    = payload_bytes[39:20];
      r.temperature_raw = payload_bytes[19:0];
      prod = 64'(r.humidity_raw) * HUM_FULL_SCALE;
      r.humidity_centi = 14'(prod >> 20);
      // wrap in 64 bits; the low 15 bits are the two's complement value
      prod = 64'(r.temperature_raw) * TEMP_FULL_SCALE;
      r.temperature_centi = 15'((prod >> 20) - TEMP_SHIFT_DOWN);
      // busy wins over a bad CRC
      if (status_byte[BUSY_BIT]) begin
        r.frame_status = FRAME_BUSY;
      end else if (crc_acc != b) begin
        r.frame_status = FRAME_CRC_ERR;
      end else begin
        r.frame_status = FRAME_OK;
      end
      r.needs_calibration = ((status_byte & CAL_MASK) != CAL_MASK);
      expected_readings.push_back(r);
      frame_pos = 3'd0;
      crc_acc   = CRC_INIT;
    end
  endtask

  task automatic compare_field(input string name, input longint unsigned want,
                               input longint unsigned got);
    if (want != got) begin
      flag_error($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
                           results_seen, name, want, got));
    end
  endtask

  // Match one accepted result against the oldest predicted reading
  task automatic check_reading(input logic [71:0] d);
    result_t want;
    if (expected_readings.size() == 0) begin
      flag_error($sformatf("result %0d arrived with no frame pending", results_seen));
    end else begin
      want = expected_readings.pop_front();
      compare_field("frame_status", want.frame_status, d[1:0]);
      compare_field("needs_calibration", want.needs_calibration, d[2]);
      compare_field("humidity_raw", want.humidity_raw, d[22:3]);
      compare_field("temperature_raw", want.temperature_raw, d[42:23]);
      compare_field("humidity_centi", want.humidity_centi, d[56:43]);
      compare_field("temperature_centi", want.temperature_centi, d[71:57]);
    end
    results_seen++;
  endtask

  // Sample both streams at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      frame_pos     = 3'd0;
      crc_acc       = CRC_INIT;
      status_byte   = '0;
      payload_bytes = '0;
      results_seen  = 0;
      expected_readings.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_reading(m_axis_tdata);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata, s_axis_tuser);
      end
    end
    frames_pending = expected_readings.size();
  end

endmodule

// ===== verif/humidity_temp_frame_decoder_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the humidity and temperature frame decoder: drives sensor frames
// with random gaps and output stalls, and gives the verdict from htfd_result_checker.
// Depends on htfd_pkg, humidity_temp_frame_decoder and htfd_result_checker.
module humidity_temp_frame_decoder_tb;
  import htfd_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 9;
  localparam int BYTE_BUDGET  = 1400;
  localparam int IDLE_LIMIT   = 2000;
  localparam int SETTLE       = 12;
  localparam int FRAME_BYTES  = 7;
  localparam int DRAIN_EVERY  = 60;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tuser;   // [0] frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // [1:0] frame_status, [2] needs_calibration,
                               // [22:3] humidity_raw, [42:23] temperature_raw,
                               // [56:43] humidity_centi, [71:57] temperature_centi
  int          fail_count;
  int          frames_pending;
  int          idle_cycles;
  int          bytes_sent;
  bit          quiet_frame;

  humidity_temp_frame_decoder i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  htfd_result_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .fail_count     (fail_count),
    .frames_pending (frames_pending)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // Stop the run when no item moves on either side for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Output side: random stalls between ready runs of random length
  initial begin
    int stall;
    int run;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 24);
      repeat (run - 1) @(negedge clk);
    end
  end

  // Offer one item after an optional gap and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic start_mark);
    int gap;
    gap = quiet_frame ? 0 : pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= start_mark;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // Send the first len bytes of a frame; the CRC byte is corrupted on request
  task automatic send_frame(input logic [7:0] status, input logic [39:0] payload,
                            input bit bad_crc, input bit mark, input int len);
    logic [7:0] octets [FRAME_BYTES];
    logic [7:0] crc;
    octets[0] = status;
    for (int i = 1; i < FRAME_BYTES - 1; i++) begin
      octets[i] = payload[8 * (5 - i) +: 8];
    end
    crc = CRC_INIT;
    for (int i = 0; i < FRAME_BYTES - 1; i++) begin
      crc = crc8_byte(crc, octets[i]);
    end
    octets[FRAME_BYTES - 1] = bad_crc ? crc ^ 8'($urandom_range(1, 255)) : crc;
    for (int i = 0; i < len; i++) begin
      send_byte(octets[i], mark && (i == 0));
    end
  endtask

  // Hold the sender until every predicted result has come out
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (frames_pending == 0);
  endtask

  initial begin
    int          roll;
    int          noise_len;
    int          frames_done;
    bit          resync;
    logic [7:0]  status;
    logic [39:0] payload;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    bytes_sent    = 0;
    quiet_frame   = 1'b0;
    frames_done   = 0;
    resync        = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Directed: good frame of zeros with no start mark, a dropped partial frame,
    // busy with bad CRC on all ones, then a bad CRC needing calibration
    send_frame(8'h18, 40'h00000_00000, 1'b0, 1'b0, FRAME_BYTES);
    send_frame(8'h1C, 40'h12345_6789A, 1'b0, 1'b1, 2);
    send_frame(8'hFF, 40'hFFFFF_FFFFF, 1'b1, 1'b1, FRAME_BYTES);
    send_frame(8'h08, 40'h80000_7FFFF, 1'b1, 1'b1, FRAME_BYTES);
    drain_results();

    // Random: mostly whole frames, some cut short, some loose bytes
    while (bytes_sent < BYTE_BUDGET) begin
      quiet_frame = ($urandom_range(0, 3) == 0);
      status      = 8'($urandom);
      status[7]   = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) != 0) status[4:3] = 2'b11;
      case ($urandom_range(0, 9))
        0:       payload = '0;
        1:       payload = '1;
        default: payload = {8'($urandom), 32'($urandom)};
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 78) begin
        send_frame(status, payload, $urandom_range(0, 3) == 0,
                   resync || ($urandom_range(0, 4) != 0), FRAME_BYTES);
        resync = 1'b0;
      end else if (roll < 90) begin
        send_frame(status, payload, 1'b0, 1'b1, $urandom_range(1, FRAME_BYTES - 1));
        resync = 1'b1;
      end else begin
        noise_len = $urandom_range(1, 8);
        repeat (noise_len) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        resync = 1'b1;
      end
      frames_done++;
      if (frames_done % DRAIN_EVERY == 0) drain_results();
    end
    quiet_frame = 1'b0;

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/htfd_pkg.sv
sv/htfd_front.sv
sv/htfd_queue.sv
sv/htfd_back.sv
sv/humidity_temp_frame_decoder.sv
verif/htfd_result_checker.sv
verif/humidity_temp_frame_decoder_tb.sv
